/* hw/rtl/ppt_pkg.sv */
// Shared constants and controller/datapath interface types for the perfect power tester.
`timescale 1ns / 1ps
package ppt_pkg;

  localparam int PPT_MAX_EXPONENT = 32;
  localparam int PPT_NUM_W        = 32;
  localparam int PPT_BOUND_W      = 16;
  localparam int PPT_WIN_W        = PPT_BOUND_W + 2;
  localparam logic [PPT_NUM_W-1:0] PPT_POW_CAP = 32'h8000_0000;

  typedef struct packed {
    logic load;       // capture a new transaction, open the search window
    logic start_pow;  // take the window midpoint, restart the power
    logic mul_res;    // result = result * base power
    logic mul_sqr;    // base power = base power squared
    logic go_up;      // lo = mid + 1
    logic go_down;    // hi = mid - 1
  } ppt_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic n_neg;
    logic window_empty;
    logic e_zero;
    logic e_lsb;
    logic eq;
    logic lt;
  } ppt_status_t;

endpackage

/* hw/rtl/perfect_power_test_core.sv */
// Top level of the perfect power tester: controller, datapath and output register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   input   | in        | in_valid / in_ready | number_in, exponent, search_upper_bound
//   output  | out       | out_valid/out_ready | is_power
//
// One transaction at a time. Zero, one and negative numbers are answered from the
// classify step with no search. Otherwise each search round runs a check step and
// then the power steps, each multiply on the single shared 32x32 saturating
// multiplier (at most 2*ExpW multiplies, 7 for exponent 32), and at most 17 rounds
// run (bound 65535).
// The result sits in an output register, so a new transaction is taken while the
// previous result still waits; a stalled output holds the controller only when a
// second result is ready. Reset (synchronous) returns to idle with no result pending.
`timescale 1ns / 1ps
module perfect_power_test_core #(
  parameter int MAX_EXPONENT = ppt_pkg::PPT_MAX_EXPONENT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [ppt_pkg::PPT_NUM_W-1:0]        number_in,
  input  logic [$clog2(MAX_EXPONENT+1)-1:0]           exponent,
  input  logic [ppt_pkg::PPT_BOUND_W-1:0]             search_upper_bound,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic                                        is_power
);
  import ppt_pkg::*;

  localparam int ExpW = $clog2(MAX_EXPONENT + 1);

  ppt_cmd_t    cmd;
  ppt_status_t status;
  logic        in_fire;
  logic        out_free;
  logic        idle;
  logic        res_valid;
  logic        res_bit;

  // Accept only while the controller is idle and out of reset.
  assign in_ready = idle && !rst;
  assign in_fire  = in_valid && in_ready;

  // The output register may be overwritten when empty or drained this cycle.
  assign out_free = !out_valid || out_ready;

  ppt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .out_free  (out_free),
    .status    (status),
    .cmd       (cmd),
    .idle      (idle),
    .res_valid (res_valid),
    .res_bit   (res_bit)
  );

  ppt_dp #(
    .ExpW (ExpW)
  ) u_dp (
    .clk                (clk),
    .number_in          (number_in),
    .exponent           (exponent),
    .search_upper_bound (search_upper_bound),
    .cmd                (cmd),
    .status             (status)
  );

  // Output register: load a finished answer, drop valid once the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      is_power <= res_bit;
    end
  end

endmodule

/* hw/rtl/ppt_dp.sv */
// Datapath: search window, shared saturating multiplier and power compare.
`timescale 1ns / 1ps
module ppt_dp #(
  parameter int ExpW = 6
) (
  input  logic                                  clk,
  input  logic signed [ppt_pkg::PPT_NUM_W-1:0]  number_in,
  input  logic [ExpW-1:0]                       exponent,
  input  logic [ppt_pkg::PPT_BOUND_W-1:0]       search_upper_bound,
  input  ppt_pkg::ppt_cmd_t                     cmd,
  output ppt_pkg::ppt_status_t                  status
);
  import ppt_pkg::*;

  logic signed [PPT_NUM_W-1:0]   n;
  logic signed [PPT_WIN_W-1:0]   lo;
  logic signed [PPT_WIN_W-1:0]   hi;
  logic [PPT_BOUND_W-1:0]        mid;
  logic [PPT_NUM_W-1:0]          result;
  logic [PPT_NUM_W-1:0]          pw;
  logic [ExpW-1:0]               eshift;
  logic [ExpW-1:0]               exponent_q;

  logic signed [PPT_WIN_W-1:0]   win_sum;
  logic [PPT_BOUND_W-1:0]        mid_calc;
  logic [PPT_NUM_W-1:0]          op_a;
  logic [2*PPT_NUM_W-1:0]        prod;
  logic [PPT_NUM_W-1:0]          prod_sat;

  // Midpoint is only used while lo <= hi, both non-negative.
  assign win_sum  = lo + hi;
  assign mid_calc = win_sum[PPT_BOUND_W:1];

  assign op_a     = cmd.mul_res ? result : pw;
  assign prod     = {{PPT_NUM_W{1'b0}}, op_a} * {{PPT_NUM_W{1'b0}}, pw};
  assign prod_sat = (prod > {{PPT_NUM_W{1'b0}}, PPT_POW_CAP}) ? PPT_POW_CAP
                                                               : prod[PPT_NUM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n  <= number_in;
      lo <= '0;
      hi <= $signed({2'b00, search_upper_bound});
    end
    if (cmd.start_pow) begin
      mid    <= mid_calc;
      pw     <= {{(PPT_NUM_W-PPT_BOUND_W){1'b0}}, mid_calc};
      result <= {{(PPT_NUM_W-1){1'b0}}, 1'b1};
      eshift <= exponent_q;
    end
    if (cmd.mul_res) begin
      result    <= prod_sat;
      eshift[0] <= 1'b0;
    end
    if (cmd.mul_sqr) begin
      pw     <= prod_sat;
      eshift <= eshift >> 1;
    end
    if (cmd.go_up) begin
      lo <= $signed({2'b00, mid}) + PPT_WIN_W'(1);
    end
    if (cmd.go_down) begin
      hi <= $signed({2'b00, mid}) - PPT_WIN_W'(1);
    end
  end

  // Exponent is captured with the transaction and reloaded each round.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exponent_q <= exponent;
    end
  end

  always_comb begin
    status.n_zero       = (n == '0);
    status.n_one        = (n == PPT_NUM_W'(1));
    status.n_neg        = n[PPT_NUM_W-1];
    status.window_empty = (lo > hi);
    status.e_zero       = (eshift == '0);
    status.e_lsb        = eshift[0];
    status.eq           = (result == $unsigned(n));
    status.lt           = (result < $unsigned(n));
  end

endmodule

/* hw/rtl/ppt_ctrl.sv */
// Controller: sequences the classify, binary-search and power steps.
`timescale 1ns / 1ps
module ppt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 out_free,
  input  ppt_pkg::ppt_status_t status,
  output ppt_pkg::ppt_cmd_t    cmd,
  output logic                 idle,
  output logic                 res_valid,
  output logic                 res_bit
);
  import ppt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_CHECK,
    S_POW,
    S_DONE
  } state_t;

  state_t state;
  logic   answer;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      answer <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) state <= S_CLASSIFY;
        end
        S_CLASSIFY: begin
          if (status.n_zero || status.n_neg) begin
            answer <= 1'b0;
            state  <= S_DONE;
          end else if (status.n_one) begin
            answer <= 1'b1;
            state  <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (status.window_empty) begin
            answer <= 1'b0;
            state  <= S_DONE;
          end else begin
            state <= S_POW;
          end
        end
        S_POW: begin
          if (status.e_zero) begin
            if (status.eq) begin
              answer <= 1'b1;
              state  <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_fire;
    cmd.start_pow = (state == S_CHECK) && !status.window_empty;
    if (state == S_POW) begin
      if (status.e_zero) begin
        cmd.go_up   = !status.eq && status.lt;
        cmd.go_down = !status.eq && !status.lt;
      end else if (status.e_lsb) begin
        cmd.mul_res = 1'b1;
      end else begin
        cmd.mul_sqr = 1'b1;
      end
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE) && out_free;
  assign res_bit   = answer;

endmodule

/* hw/rtl/ppt_checker.sv */
// Port-level checks for the perfect power tester, bound to the top level.
`timescale 1ns / 1ps
module ppt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_power
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(is_power))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // One transaction at a time: no accept right after an accept.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // A result never appears in the cycle right after an accept.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early after accept");

endmodule

bind perfect_power_test_core ppt_checker u_ppt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .is_power  (is_power)
);

/* tb/perfect_power_test_core_test.sv */
// Self-checking testbench for the perfect power tester core.
`timescale 1ns / 1ps
module perfect_power_test_core_test;
  import ppt_pkg::*;

  localparam int EXP_W        = $clog2(PPT_MAX_EXPONENT + 1);
  localparam int RANDOM_TESTS = 1250;
  localparam int QUIET_LIMIT  = 4000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES  = 300;   // longer than one full search
  localparam logic [63:0] SAT_LEVEL = 64'h8000_0000;
  localparam logic [63:0] INT_MAX   = 64'h7FFF_FFFF;

  // Flavors of random test.
  typedef enum int {
    GEN_POWER,    // exact root^e with a sane bound
    GEN_NEAR,     // one off an exact power
    GEN_NOISE,    // all fields uniform over their full width
    GEN_SPECIAL   // zero, one, negative, odd exponents and bounds
  } gen_kind_t;

  // Receiver behavior, switched at random by the monitor.
  typedef enum int {
    RX_OPEN,
    RX_CHOPPY,
    RX_SLOW
  } rx_mode_t;

  typedef struct {
    logic signed [PPT_NUM_W-1:0] number;
    logic [EXP_W-1:0]            power_e;
    logic [PPT_BOUND_W-1:0]      bound;
    bit                          drain_first;  // hold until all answers are back
  } power_query_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [PPT_NUM_W-1:0] number_in = '0;
  logic [EXP_W-1:0]            exponent = '0;
  logic [PPT_BOUND_W-1:0]      search_upper_bound = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        is_power;

  power_query_t query_q[$];        // tests not yet offered to the block
  bit           expected_answers[$];
  int unsigned  root_limit[64];    // greatest m with m^e <= 2^31-1, capped at the field
  int           mismatches = 0;
  int           sent_count = 0;
  int           checked_count = 0;
  int           powers_seen = 0;
  int           quiet_cycles = 0;

  perfect_power_test_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .number_in          (number_in),
    .exponent           (exponent),
    .search_upper_bound (search_upper_bound),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .is_power           (is_power)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // base^e formed exactly, clipped at 2^31; a clipped value beats any positive signed 32-bit number.
  function automatic logic [63:0] sat_power(input logic [63:0] base, input int unsigned e);
    logic [63:0] acc;
    acc = 64'd1;
    for (int unsigned i = 0; i < e; i++) begin
      acc = acc * base;
      if (acc > SAT_LEVEL) acc = SAT_LEVEL;
    end
    return acc;
  endfunction

  // Binary search for an integer root over 0..bound.
  function automatic bit power_answer(input logic signed [PPT_NUM_W-1:0] n,
                                      input logic [EXP_W-1:0] e,
                                      input logic [PPT_BOUND_W-1:0] bound);
    int          lo;
    int          hi;
    int          mid;
    logic [63:0] target;
    logic [63:0] v;
    if (n == 0) return 1'b0;
    if (n == 1) return 1'b1;
    if (n < 0) return 1'b0;
    target = {32'd0, n};
    lo = 0;
    hi = int'(bound);
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      v = sat_power(64'(mid), 32'(e));
      if (v == target) return 1'b1;
      if (v < target) lo = mid + 1;
      else hi = mid - 1;
    end
    return 1'b0;
  endfunction

  function automatic power_query_t make_query(input logic [31:0] n, input int unsigned e,
                                              input int unsigned bound);
    power_query_t q;
    q.number      = n;
    q.power_e     = EXP_W'(e);
    q.bound       = PPT_BOUND_W'(bound);
    q.drain_first = 1'b0;
    return q;
  endfunction

  // Append a test to the end of the pending list.
  function automatic void queue_query(input power_query_t q);
    query_q.insert(query_q.size(), q);
  endfunction

  // Driver: offer queued tests in bursts, with random gaps that land on every
  // phase of the search. The payload only changes once the current transaction
  // has gone through.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : drive_proc
    power_query_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_answers.insert(expected_answers.size(),
                                power_answer(number_in, exponent, search_upper_bound));
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (query_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (query_q[0].drain_first && expected_answers.size() != 0) begin
          // Hold off until the block has returned every answer.
          in_valid <= 1'b0;
        end else begin
          nxt = query_q.pop_front();
          in_valid           <= 1'b1;
          number_in          <= nxt.number;
          exponent           <= nxt.power_e;
          search_upper_bound <= nxt.bound;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            // Start a new burst; a third of the time with no gap at all.
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end
        end
      end
    end
  end

  // Monitor: check each answer against the oldest prediction, and drive the
  // receiver's stall pattern.
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;

  always @(posedge clk) begin : monitor_proc
    bit want;
    if (!rst && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: answer with none pending: expected none, actual is_power=%0b",
                 $time, is_power);
        mismatches++;
      end else begin
        want = expected_answers.pop_front();
        checked_count++;
        if (want) powers_seen++;
        if (is_power !== want) begin
          $display("%0t: is_power mismatch on answer %0d: expected %0b, actual %0b",
                   $time, checked_count, want, is_power);
          mismatches++;
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(200, 2000);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
      default:   out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : main_proc
    power_query_t q;
    gen_kind_t    kind;
    int unsigned  e;
    int unsigned  r;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    int unsigned  pick;
    logic [63:0]  p;
    bit           timed_out;

    // Largest root whose power still fits a positive 32-bit number.
    for (int k = 0; k < 64; k++) begin
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (sat_power(64'(mid), k) <= INT_MAX) lo = mid;
        else hi = mid - 1;
      end
      root_limit[k] = lo;
    end

    // Directed tests: special numbers, extreme fields, exact powers and near misses.
    queue_query(make_query(32'd0, 2, 46340));              // zero
    queue_query(make_query(32'd1, 0, 0));                  // one, zero bound
    queue_query(make_query(32'd1, 63, 65535));             // one, widest exponent
    queue_query(make_query(32'hFFFF_FFFF, 2, 46340));      // minus one
    queue_query(make_query(32'h8000_0000, 3, 1290));       // most negative
    queue_query(make_query(32'h7FFF_FFFF, 2, 46340));      // largest, not a square
    queue_query(make_query(32'h7FFF_FFFF, 1, 65535));      // beyond every candidate
    queue_query(make_query(32'd65535, 1, 65535));          // exponent one, top bound
    queue_query(make_query(32'd2147395600, 2, 46340));     // 46340^2
    queue_query(make_query(32'h4000_0000, 30, 2));         // 2^30
    queue_query(make_query(32'h4000_0001, 30, 2));         // just past 2^30
    queue_query(make_query(32'h4000_0000, 2, 65535));      // 32768^2, clipped upper half
    queue_query(make_query(32'd1162261467, 19, 3));        // 3^19
    queue_query(make_query(32'd43046721, 16, 3));          // 3^16
    queue_query(make_query(32'd16, 4, 2));                 // root at the bound
    queue_query(make_query(32'd36, 2, 5));                 // root above the bound
    queue_query(make_query(32'd5, 2, 0));                  // only candidate zero
    queue_query(make_query(32'd4, 0, 100));                // exponent zero
    queue_query(make_query(32'd2, 2, 65535));              // search miss
    queue_query(make_query(32'd2, 63, 65535));             // everything saturates
    queue_query(make_query(32'd65536, 32, 1));             // 2^16, no root within bound
    queue_query(make_query(32'd1024, 10, 8));              // 2^10

    // Random tests, weighted toward exact powers and near misses so that the
    // search runs deep and ends on both answers.
    for (int t = 0; t < RANDOM_TESTS; t++) begin
      pick = $urandom_range(0, 15);
      if (pick <= 8) kind = GEN_POWER;
      else if (pick <= 11) kind = GEN_NEAR;
      else if (pick <= 13) kind = GEN_NOISE;
      else kind = GEN_SPECIAL;
      case (kind)
        GEN_POWER, GEN_NEAR: begin
          e = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 32);
          r = $urandom_range(0, root_limit[e]);
          p = sat_power(64'(r), e);
          if (kind == GEN_NEAR) p = (p < INT_MAX) ? p + 1 : p - 1;
          q = make_query(p[31:0], e,
                         ($urandom_range(0, 3) != 0) ? root_limit[e] : $urandom_range(0, 65535));
        end
        GEN_NOISE: begin
          q = make_query($urandom, $urandom_range(0, 63), $urandom_range(0, 65535));
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       p = 64'd0;
            1:       p = 64'd1;
            default: p = {33'd1, 31'($urandom)};
          endcase
          q = make_query(p[31:0], $urandom_range(0, 63), $urandom_range(0, 65535));
        end
      endcase
      // Drain the block before the random part and again halfway through.
      q.drain_first = (t == 0) || (t == RANDOM_TESTS / 2);
      queue_query(q);
    end

    // Hold reset, then drop it.
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Sample between edges so the driver's and monitor's updates have settled.
    timed_out = 1'b0;
    while (!(query_q.size() == 0 && !in_valid && expected_answers.size() == 0)) begin
      @(negedge clk);
      if (quiet_cycles >= QUIET_LIMIT) begin
        timed_out = 1'b1;
        break;
      end
    end
    // Let any stray answer show up before closing.
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);

    if (!timed_out && (expected_answers.size() != 0 || checked_count != sent_count)) begin
      $display("%0t: answers missing: expected %0d, actual %0d",
               $time, sent_count, checked_count);
      mismatches++;
    end

    if (timed_out) begin
      $display("%0t: no transaction for %0d cycles, %0d answers outstanding",
               $time, QUIET_LIMIT, expected_answers.size());
      $display("FAIL");
    end else begin
      $display("Checked %0d of %0d power tests (%0d exact powers), exponents 0-63,",
               checked_count, sent_count, powers_seen);
      $display("bounds 0-65535, with sender gaps and receiver stalls; %0d mismatches.",
               mismatches);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
    end
    $finish;
  end

endmodule

/* perfect_power_test_core.f */
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_dp.sv
hw/rtl/ppt_ctrl.sv
hw/rtl/perfect_power_test_core.sv
hw/rtl/ppt_checker.sv
tb/perfect_power_test_core_test.sv
